// ----- rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Silence split detector package
// Shared widths, register indexes, reset values and the result record type.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int FRAME_BITS  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int OUT_BITS    = 32;

   localparam int LEVEL_BITS  = 16;
   localparam int SECS_BITS   = 16;
   localparam int RATE_BITS   = 18;
   localparam int CSR_BITS    = 18;
   localparam int CSR_IDX_BITS = 2;

   // (seconds + 1) * rate
   localparam int THR_BITS    = SECS_BITS + 1 + RATE_BITS;
   localparam int CMP_BITS    = (FRAME_BITS > THR_BITS) ? FRAME_BITS : THR_BITS;

   localparam int REQ_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 4 * OUT_BITS;

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET   = LEVEL_BITS'(10);
   localparam logic [SECS_BITS-1:0]  SECONDS_RESET = SECS_BITS'(60);
   localparam logic [RATE_BITS-1:0]  RATE_RESET    = RATE_BITS'(44100);
   localparam logic [THR_BITS-1:0]   THR_RESET     = THR_BITS'((60 + 1) * 44100);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SILENCE_LEVEL   = 2'd0,
      CSR_SILENCE_SECONDS = 2'd1,
      CSR_SAMPLE_RATE     = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_SEGMENT = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   // Results caused by one item: an optional segment, then an optional summary.
   typedef struct packed {
      logic                  has_seg;
      logic                  has_sum;
      logic [OUT_BITS-1:0]   part;
      logic [OUT_BITS-1:0]   seg_start;
      logic [OUT_BITS-1:0]   seg_stop;
      logic [OUT_BITS-1:0]   longest;
   } rec_type;

endpackage

// ----- rtl/silence_split_detector.sv -----
// ----------------------------------------------------------------------------
// Silence split detector
// Finds long silent runs in a stereo frame stream and reports the segments
// between them, then a summary with the longest silence at end of stream.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)          | tuser       | tlast
//  --------+-----------+-----------------------------+-------------+---------------
//  req_    | in        | left_sample, right_sample   | -           | end_of_stream
//  rsp_    | out       | part_number, segment_start, | result_kind | last_result
//          |           | segment_stop, longest_silence|            |
//  csr_    | in        | write enable / index / data | -           | -
//
//  One frame per cycle: a frame is registered on transfer, classified and
//  folded into the run state from the input register, and its results land in
//  a two-record output buffer. The split threshold (seconds + 1) * rate is a
//  registered product of the configuration, so the per-frame path holds one
//  subtract and compare. The end item emits two transfers when it also closes
//  a segment. Reset is synchronous and clears all control state; no clearing
//  pass. A stalled result side fills the record buffer, then holds req_tready.
//
module silence_split_detector (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ssd_pkg::REQ_DATA_BITS-1:0]      req_tdata,   // left_sample, right_sample
   input  logic                                   req_tlast,   // end_of_stream

   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ssd_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,   // part_number, segment_start,
                                                               // segment_stop, longest_silence
   output logic                                   rsp_tuser,   // result_kind
   output logic                                   rsp_tlast,   // last_result

   input  logic                                   csr_wr_en,
   input  logic [ssd_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [ssd_pkg::CSR_BITS-1:0]           csr_wdata
);

   localparam int SB = ssd_pkg::SAMPLE_BITS;
   localparam int FB = ssd_pkg::FRAME_BITS;
   localparam int OB = ssd_pkg::OUT_BITS;

   // ------------------------------------------------------------------
   // Configuration registers and split threshold
   // ------------------------------------------------------------------
   logic [ssd_pkg::LEVEL_BITS-1:0] level_ff,   level_in;
   logic [ssd_pkg::SECS_BITS-1:0]  seconds_ff, seconds_in;
   logic [ssd_pkg::RATE_BITS-1:0]  rate_ff,    rate_in;
   logic [ssd_pkg::RATE_BITS-1:0]  rate_eff;
   logic [ssd_pkg::THR_BITS-1:0]   thr_ff,     thr_in;

   always_comb begin
      level_in   = level_ff;
      seconds_in = seconds_ff;
      rate_in    = rate_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ssd_pkg::CSR_SILENCE_LEVEL:   level_in   = csr_wdata[ssd_pkg::LEVEL_BITS-1:0];
            ssd_pkg::CSR_SILENCE_SECONDS: seconds_in = csr_wdata[ssd_pkg::SECS_BITS-1:0];
            ssd_pkg::CSR_SAMPLE_RATE:     rate_in    = csr_wdata[ssd_pkg::RATE_BITS-1:0];
            default: ;   // unmapped index: drop the write
         endcase
      end
      // A zero rate counts as one frame per second.
      rate_eff = (rate_in == '0) ? ssd_pkg::RATE_BITS'(1) : rate_in;
      // floor(run / rate) > seconds  <=>  run >= (seconds + 1) * rate
      thr_in   = ssd_pkg::THR_BITS'(({1'b0, seconds_in} + 1'b1))
                 * ssd_pkg::THR_BITS'(rate_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= ssd_pkg::LEVEL_RESET;
         seconds_ff <= ssd_pkg::SECONDS_RESET;
         rate_ff    <= ssd_pkg::RATE_RESET;
         thr_ff     <= ssd_pkg::THR_RESET;
      end else begin
         level_ff   <= level_in;
         seconds_ff <= seconds_in;
         rate_ff    <= rate_in;
         thr_ff     <= thr_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic          s1_valid_ff;
   logic [SB-1:0] s1_left_ff, s1_right_ff;
   logic          s1_end_ff;
   logic          s1_fire;
   logic          skid_valid_ff;

   // Hold the frame while the record buffer is full.
   assign s1_fire    = s1_valid_ff && !skid_valid_ff;
   assign req_tready = !s1_valid_ff || !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_left_ff  <= req_tdata[SB-1:0];
         s1_right_ff <= req_tdata[2*SB-1:SB];
         s1_end_ff   <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Frame classification and run state
   // ------------------------------------------------------------------
   function automatic logic [SB:0] magnitude(input logic [SB-1:0] x);
      logic [SB:0] ext;
      begin
         ext = {x[SB-1], x};
         magnitude = x[SB-1] ? (~ext + 1'b1) : ext;
      end
   endfunction

   logic [FB-1:0] frame_ff,      frame_in;
   logic          sil_act_ff,    sil_act_in;
   logic [FB-1:0] sil_start_ff,  sil_start_in;
   logic          noise_act_ff,  noise_act_in;
   logic [FB-1:0] noise_start_ff, noise_start_in;
   logic [OB-1:0] part_ff,       part_in;
   logic [FB-1:0] max_run_ff,    max_run_in;

   logic          silent;
   logic [FB-1:0] run_len;
   logic [FB-1:0] run;
   logic          long_run;
   logic          close_seg;
   logic [OB-1:0] part_next;
   logic          push;
   ssd_pkg::rec_type push_rec;

   always_comb begin
      silent = !s1_end_ff
               && (32'(magnitude(s1_left_ff))  < 32'(level_ff))
               && (32'(magnitude(s1_right_ff)) < 32'(level_ff));

      // Run length wraps at the frame counter width.
      run_len   = frame_ff - sil_start_ff;
      // Run length so far; a run that starts on this frame has length zero.
      run       = sil_act_ff ? run_len : '0;
      long_run  = ssd_pkg::CMP_BITS'(run_len) >= ssd_pkg::CMP_BITS'(thr_ff);
      close_seg = !silent && sil_act_ff && noise_act_ff
                  && ((s1_end_ff && part_ff != '0) || long_run);
      part_next = close_seg ? part_ff + 1'b1 : part_ff;

      frame_in       = frame_ff;
      sil_act_in     = sil_act_ff;
      sil_start_in   = sil_start_ff;
      noise_act_in   = noise_act_ff;
      noise_start_in = noise_start_ff;
      part_in        = part_ff;
      max_run_in     = max_run_ff;

      if (silent) begin
         if (!sil_act_ff) begin
            sil_act_in   = 1'b1;
            sil_start_in = frame_ff;
         end
         if (run > max_run_ff) begin
            max_run_in = run;
         end
         frame_in = frame_ff + 1'b1;
      end else if (s1_end_ff) begin
         // End of stream: back to the reset state.
         frame_in       = '0;
         sil_act_in     = 1'b0;
         sil_start_in   = '0;
         noise_act_in   = 1'b0;
         noise_start_in = '0;
         part_in        = '0;
         max_run_in     = '0;
      end else begin
         // A closed segment restarts noise at this frame.
         if (!noise_act_ff || close_seg) begin
            noise_start_in = frame_ff;
         end
         noise_act_in = 1'b1;
         sil_act_in   = 1'b0;
         part_in      = part_next;
         frame_in     = frame_ff + 1'b1;
      end

      push               = s1_fire && (close_seg || s1_end_ff);
      push_rec.has_seg   = close_seg;
      push_rec.has_sum   = s1_end_ff;
      push_rec.part      = part_next;
      push_rec.seg_start = OB'(noise_start_ff);
      push_rec.seg_stop  = OB'(sil_start_ff);
      push_rec.longest   = OB'(max_run_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff       <= '0;
         sil_act_ff     <= 1'b0;
         sil_start_ff   <= '0;
         noise_act_ff   <= 1'b0;
         noise_start_ff <= '0;
         part_ff        <= '0;
         max_run_ff     <= '0;
      end else if (s1_fire) begin
         frame_ff       <= frame_in;
         sil_act_ff     <= sil_act_in;
         sil_start_ff   <= sil_start_in;
         noise_act_ff   <= noise_act_in;
         noise_start_ff <= noise_start_in;
         part_ff        <= part_in;
         max_run_ff     <= max_run_in;
      end
   end

   // ------------------------------------------------------------------
   // Record buffer: head record on the port, one skid record behind it
   // ------------------------------------------------------------------
   logic             head_valid_ff;
   ssd_pkg::rec_type head_ff, skid_ff;
   logic             phase_ff;       // set once the segment of the head went out
   logic             show_seg;
   logic             rsp_last;
   logic             pop;

   assign show_seg = head_ff.has_seg && !phase_ff;
   assign rsp_last = !show_seg || !head_ff.has_sum;
   assign pop      = head_valid_ff && rsp_tready && rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         if (head_valid_ff && rsp_tready) begin
            phase_ff <= !rsp_last;
         end
         if (pop) begin
            // Advance: a new record never arrives while the skid is full.
            head_valid_ff <= skid_valid_ff || push;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            if (head_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               head_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= skid_valid_ff ? skid_ff : push_rec;
      end else if (push) begin
         if (head_valid_ff) begin
            skid_ff <= push_rec;
         end else begin
            head_ff <= push_rec;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result port
   // ------------------------------------------------------------------
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tlast  = rsp_last;
   assign rsp_tuser  = show_seg ? ssd_pkg::KIND_SEGMENT : ssd_pkg::KIND_SUMMARY;
   assign rsp_tdata  = {show_seg ? '0 : head_ff.longest,
                        show_seg ? head_ff.seg_stop  : '0,
                        show_seg ? head_ff.seg_start : '0,
                        head_ff.part};

endmodule

// ----- rtl/ssd_checker.sv -----
// ----------------------------------------------------------------------------
// Silence split detector checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ssd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   localparam int OB = ssd_pkg::OUT_BITS;

   // A summary always closes the results of its item.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ssd_pkg::KIND_SUMMARY |-> rsp_tlast)
      else $error("summary transfer without last flag");

   // A summary carries no segment bounds; a segment carries no longest run.
   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tuser == ssd_pkg::KIND_SUMMARY && rsp_tdata[3*OB-1:OB] == '0) ||
         (rsp_tuser == ssd_pkg::KIND_SEGMENT && rsp_tdata[4*OB-1:3*OB] == '0))
      else $error("unused result fields not zero");

   // A segment that is not last is followed at once by its summary.
   a_seg_then_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser == ssd_pkg::KIND_SUMMARY)
      else $error("segment without last not followed by summary");

   // Hold a stalled result.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind silence_split_detector ssd_checker u_ssd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/tb_silence_split_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Silence split detector testbench
// Streams stereo frames and end markers through the block under a series of
// register settings, predicts each segment and summary result in a
// scoreboard, and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_silence_split_detector;
   import ssd_pkg::*;

   localparam int ITEMS       = 1150;  // random frames and markers after the directed part
   localparam int PHASE_ITEMS = 120;   // items per register setting
   localparam int CALM_ITEMS  = 150;   // tail of the run without idling
   localparam int SETTLE      = 8;     // wait for the pipeline and the threshold register to settle
   localparam int LONG_HOLD   = 300;   // receiver hold-off that backs up the block
   localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

   // -------------------------------------------------------------------------
   // Scoreboard: tracks silent runs and segments, queues the expected results
   // -------------------------------------------------------------------------
   class split_scoreboard;
      typedef struct packed {
         result_kind_type     kind;
         logic [OUT_BITS-1:0] part;
         logic [OUT_BITS-1:0] start;
         logic [OUT_BITS-1:0] stop;
         logic [OUT_BITS-1:0] longest;
         logic                last;
      } split_rec_type;

      split_rec_type expected_splits[$];
      int unsigned errors;

      logic [LEVEL_BITS-1:0] level;
      logic [SECS_BITS-1:0]  secs;
      logic [RATE_BITS-1:0]  rate;

      logic [FRAME_BITS-1:0] frame_idx;
      logic [FRAME_BITS-1:0] silence_from;
      logic [FRAME_BITS-1:0] noise_from;
      logic [FRAME_BITS-1:0] longest_run;
      logic                  in_silence;
      logic                  in_noise;
      logic [OUT_BITS-1:0]   parts;

      function new();
         level  = LEVEL_RESET;
         secs   = SECONDS_RESET;
         rate   = RATE_RESET;
         errors = 0;
         clear_run();
      endfunction

      function void clear_run();
         frame_idx    = '0;
         silence_from = '0;
         noise_from   = '0;
         longest_run  = '0;
         in_silence   = 1'b0;
         in_noise     = 1'b0;
         parts        = '0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_BITS-1:0] value);
         case (idx)
            CSR_SILENCE_LEVEL:   level = value[LEVEL_BITS-1:0];
            CSR_SILENCE_SECONDS: secs  = value[SECS_BITS-1:0];
            CSR_SAMPLE_RATE:     rate  = value[RATE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // -32768 has magnitude 32768, hence one extra bit
      function logic [SAMPLE_BITS:0] magnitude(logic [SAMPLE_BITS-1:0] s);
         logic [SAMPLE_BITS:0] m;
         m = s[SAMPLE_BITS-1] ? ({1'b0, ~s} + 1'b1) : {1'b0, s};
         return m;
      endfunction

      function int pending();
         return expected_splits.size();
      endfunction

      // Fold one accepted frame or end marker into the run state.
      function void note_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                               logic eos);
         logic [FRAME_BITS-1:0] run;
         logic [FRAME_BITS-1:0] rate_eff;
         split_rec_type         rec;
         if (!eos && magnitude(l) < {1'b0, level} && magnitude(r) < {1'b0, level}) begin
            if (!in_silence) begin
               in_silence   = 1'b1;
               silence_from = frame_idx;
            end
            run = frame_idx - silence_from;
            if (run > longest_run)
               longest_run = run;
            frame_idx = frame_idx + 1'b1;
            return;
         end
         // a zero rate counts as one frame per second
         rate_eff = (rate == '0) ? FRAME_BITS'(1) : FRAME_BITS'(rate);
         run      = frame_idx - silence_from;
         if (in_silence && in_noise &&
             ((eos && parts != '0) || run / rate_eff > FRAME_BITS'(secs))) begin
            parts = parts + 1'b1;
            rec   = '{KIND_SEGMENT, parts, noise_from, silence_from, '0, ~eos};
            expected_splits.push_back(rec);
            in_noise = 1'b0;
         end
         if (eos) begin
            rec = '{KIND_SUMMARY, parts, '0, '0, longest_run, 1'b1};
            expected_splits.push_back(rec);
            clear_run();
            return;
         end
         if (!in_noise) begin
            in_noise   = 1'b1;
            noise_from = frame_idx;
         end
         in_silence = 1'b0;
         frame_idx  = frame_idx + 1'b1;
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare(string name, logic [OUT_BITS-1:0] got, logic [OUT_BITS-1:0] want);
         if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_result(logic kind, logic [OUT_BITS-1:0] part, logic [OUT_BITS-1:0] start,
                        logic [OUT_BITS-1:0] stop, logic [OUT_BITS-1:0] longest,
                        logic last);
         split_rec_type want;
         if (expected_splits.size() == 0) begin
            report($sformatf("unexpected result kind %0d part %0d", kind, part));
            return;
         end
         want = expected_splits.pop_front();
         compare("result_kind", OUT_BITS'(kind), OUT_BITS'(want.kind));
         compare("part_number", part, want.part);
         compare("segment_start", start, want.start);
         compare("segment_stop", stop, want.stop);
         compare("longest_silence", longest, want.longest);
         compare("last_result", OUT_BITS'(last), OUT_BITS'(want.last));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;     // left_sample, right_sample
   logic                     req_tlast  = 1'b0;   // end_of_stream

   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;           // part_number, segment_start,
                                                  // segment_stop, longest_silence
   logic                     rsp_tuser;           // result_kind
   logic                     rsp_tlast;           // last_result

   logic                     csr_wr_en  = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index  = CSR_SILENCE_LEVEL;
   logic [CSR_BITS-1:0]      csr_wdata  = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   silence_split_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   split_scoreboard sb;

   // Register copies used to shape the stimulus
   int unsigned cur_level = LEVEL_RESET;
   int unsigned cur_secs  = SECONDS_RESET;
   int unsigned cur_rate  = RATE_RESET;

   int item_count  = 0;    // accepted items after the directed part starts
   int holds_asked = 0;    // long receiver hold-offs requested by the stimulus
   bit req_gaps    = 1'b1;
   bit rsp_gaps    = 1'b1;

   // -------------------------------------------------------------------------
   // Monitor: note every input transfer, check every result transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_frame(req_tdata[SAMPLE_BITS-1:0],
                          req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[OUT_BITS-1:0],
                            rsp_tdata[2*OUT_BITS-1:OUT_BITS],
                            rsp_tdata[3*OUT_BITS-1:2*OUT_BITS],
                            rsp_tdata[4*OUT_BITS-1:3*OUT_BITS], rsp_tlast);
      end
   end

   // -------------------------------------------------------------------------
   // Result sink: random stall bursts, plus a long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : sink
      int served;
      served = 0;
      forever begin
         if (holds_asked > served) begin
            // hold off long enough for the record buffer to fill and back up
            served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: stop the run once nothing has moved for too long
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_silence_split_detector NOT OK");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------

   // Offer one item and hold it until the transfer; an idle burst may come first.
   task automatic send_item(int l, int r, bit eos);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {SAMPLE_BITS'(r), SAMPLE_BITS'(l)};
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      item_count++;
   endtask

   // Drop valid and wait until every expected result has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drain, then let frames that produce no result clear the pipeline.
   task automatic finish_phase();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_BITS'(value);
      @(posedge clock);
      sb.set_reg(idx, CSR_BITS'(value));
   endtask

   // Write all three registers back to back; only called while the block is idle.
   task automatic apply_config(int unsigned level, int unsigned secs, int unsigned rate);
      write_reg(CSR_SILENCE_LEVEL, level);
      write_reg(CSR_SILENCE_SECONDS, secs);
      write_reg(CSR_SAMPLE_RATE, rate);
      csr_wr_en <= 1'b0;
      cur_level = level & 32'hFFFF;
      cur_secs  = secs & 32'hFFFF;
      cur_rate  = rate & 32'h3FFFF;
      // give the registered split threshold time to follow
      repeat (SETTLE) @(posedge clock);
   endtask

   // Sample below the level; the boundary magnitude comes up often.
   function automatic int quiet_sample();
      int unsigned top, mag;
      top = (cur_level > 32768) ? 32768 : cur_level - 1;
      mag = ($urandom_range(0, 3) == 0) ? top : $urandom_range(0, top);
      return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
   endfunction

   // Sample at or above the level; only valid while the level is reachable.
   function automatic int loud_sample();
      int unsigned mag;
      mag = ($urandom_range(0, 3) == 0) ? cur_level : $urandom_range(cur_level, 32768);
      return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
   endfunction

   task automatic send_quiet();
      if (cur_level == 0)
         send_item($urandom, $urandom, 1'b0);
      else
         send_item(quiet_sample(), quiet_sample(), 1'b0);
   endtask

   task automatic send_loud();
      int loud, other;
      if (cur_level > 32768) begin
         // every magnitude is below the level, nothing can be loud
         send_item($urandom, $urandom, 1'b0);
      end else begin
         loud  = loud_sample();
         other = (cur_level != 0 && $urandom_range(0, 1)) ? quiet_sample() : int'($urandom);
         if ($urandom_range(0, 1))
            send_item(loud, other, 1'b0);
         else
            send_item(other, loud, 1'b0);
      end
   endtask

   // Noise and silence bursts, with silent run lengths around the split threshold
   // when it is small, usually closed by an end marker carrying junk samples.
   task automatic send_split_stream();
      longint thr;
      int     len;
      thr = (longint'(cur_secs) + 1) * ((cur_rate == 0) ? 1 : longint'(cur_rate));
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_quiet();
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(1, 4)) send_loud();
         if (thr <= 48) begin
            case ($urandom_range(0, 2))
               0:       len = int'(thr) - 1;
               1:       len = int'(thr);
               default: len = $urandom_range(0, int'(thr) + 2);
            endcase
         end else begin
            len = $urandom_range(0, 6);
         end
         repeat (len) send_quiet();
      end
      // trailing noise is never reported
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_loud();
      if ($urandom_range(0, 5) != 0)
         send_item($urandom, $urandom, 1'b1);
   endtask

   // Unshaped items with stray end markers.
   task automatic send_noise_burst();
      repeat ($urandom_range(1, 10))
         send_item($urandom, $urandom, $urandom_range(0, 7) == 0);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int phase, phase_start, random_start;
      bit paused;
      sb = new();
      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: level 10, 60 seconds at 44100 frames per second.
      send_item(0, 0, 1'b1);                 // end marker on an empty stream
      send_item(32767, 32767, 1'b0);         // largest positive samples
      send_item(-32768, -32768, 1'b0);       // most negative samples
      send_item(9, -9, 1'b0);                // just below the level: silent
      send_item(0, 0, 1'b0);
      send_item(10, 0, 1'b0);                // magnitude equal to the level is loud
      send_item(-10, 9, 1'b0);
      send_item(-9, 9, 1'b0);
      send_item(-1, -1, 1'b1);               // end marker ignores its samples
      finish_phase();

      // One frame per second and zero seconds: any silence splits.
      apply_config(10, 0, 1);
      send_item(100, 0, 1'b0);
      send_item(0, 0, 1'b0);
      send_item(1, -1, 1'b0);
      send_item(0, -500, 1'b0);              // closes the first segment
      send_item(3, 3, 1'b0);
      send_item(-20, 0, 1'b0);               // second segment
      send_item(0, 0, 1'b0);
      send_item(0, 0, 1'b1);                 // end closes a segment once parts exist
      send_item(0, 0, 1'b0);                 // stream that opens with silence
      send_item(0, 0, 1'b0);
      send_item(50, 50, 1'b0);
      send_item(0, 0, 1'b0);
      send_item(0, 0, 1'b1);
      send_item(30000, -30000, 1'b0);        // trailing noise only
      send_item(0, 0, 1'b1);
      finish_phase();

      // Random part, one register setting per phase.
      random_start = item_count;
      phase = 0;
      while (item_count - random_start < ITEMS) begin
         case (phase)
            0:       apply_config(0, 0, 1);              // level zero: nothing is silent
            1:       apply_config(65535, 1, 2);          // level above every magnitude
            2:       apply_config(32768, 0, 0);          // zero rate counts as one
            3:       apply_config(16, 65535, 192000);    // largest seconds and a high rate
            4:       apply_config(1, 0, 1);              // only zero samples are silent
            default: apply_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                            : $urandom_range(1, 600),
                                  $urandom_range(0, 3), $urandom_range(0, 5));
         endcase
         if (phase == 4)
            holds_asked++;
         phase_start = item_count;
         while (item_count - phase_start < PHASE_ITEMS &&
                item_count - random_start < ITEMS) begin
            // idle in stretches, and not at all near the end
            req_gaps = (item_count - random_start < ITEMS - CALM_ITEMS) &&
                       $urandom_range(0, 3) != 0;
            rsp_gaps = (item_count - random_start < ITEMS - CALM_ITEMS) &&
                       $urandom_range(0, 3) != 0;
            if (phase == 5 && !paused && item_count - phase_start >= PHASE_ITEMS / 2) begin
               // hold the sender mid-stream until every result is out
               wait_drained();
               paused = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
               send_noise_burst();
            else
               send_split_stream();
         end
         finish_phase();
         phase++;
      end

      if (sb.errors == 0)
         $display("tb_silence_split_detector OK");
      else
         $display("tb_silence_split_detector NOT OK");
      $finish;
   end

endmodule
